// ===== src/ppah_pkg.sv =====
`default_nettype none

package ppah_pkg;

    localparam int RIV_W     = 13;
    localparam int MODE_W    = 3;
    localparam int PRB_W     = 7;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_NONE        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_QUARTER     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NEG_QUARTER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HALF        = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TYPE2       = 3'd4;

    localparam logic [KIND_W-1:0] HOP_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] HOP_TYPE1 = 2'd1;
    localparam logic [KIND_W-1:0] HOP_TYPE2 = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRB_COUNT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOPPING_OFFSET = 1'd1;

    localparam logic [PRB_W-1:0] PRB_COUNT_RESET      = 7'd100;
    localparam logic [PRB_W-1:0] HOPPING_OFFSET_RESET = 7'd0;

    // Values derived from the configuration registers.
    typedef struct packed {
        logic [PRB_W-1:0] n;
        logic [PRB_W-1:0] half_ho;
        logic             hop_bad;
        logic [PRB_W-1:0] w;
        logic [PRB_W-1:0] w_quarter;
        logic [PRB_W-1:0] w_half;
    } cfg_t;

    // One restoring division step: {quotient bit, new remainder}.
    // Requires rem < d.
    function automatic logic [PRB_W:0] div_step(
        input logic [PRB_W-1:0] rem,
        input logic             din,
        input logic [PRB_W-1:0] d
    );
        logic [PRB_W:0] t;
        logic [PRB_W:0] diff;
        t    = {rem, din};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
        begin
            return {1'b1, diff[PRB_W-1:0]};
        end
        return {1'b0, t[PRB_W-1:0]};
    endfunction

endpackage

`default_nettype wire

// ===== src/ppah_if.sv =====
`default_nettype none

interface ppah_in_if import ppah_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [RIV_W-1:0]  riv;
    logic [MODE_W-1:0] mode;

    modport source (output valid, riv, mode, input ready);
    modport sink   (input valid, riv, mode, output ready);
endinterface

interface ppah_out_if import ppah_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PRB_W-1:0]  block_count;
    logic [PRB_W-1:0]  start_slot0;
    logic [PRB_W-1:0]  start_slot1;
    logic [KIND_W-1:0] hop_kind;
    logic              status;

    modport source (output valid, block_count, start_slot0, start_slot1, hop_kind, status,
                    input ready);
    modport sink   (input valid, block_count, start_slot0, start_slot1, hop_kind, status,
                    output ready);
endinterface

interface ppah_cfg_if import ppah_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PRB_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/ppah_cfg.sv =====
`default_nettype none

module ppah_cfg import ppah_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    ppah_cfg_if.sink        cfg,
    output cfg_t            info
);

    logic [PRB_W-1:0] n_reg;
    logic [PRB_W-1:0] h_reg;
    cfg_t             info_reg;
    cfg_t             info_next;

    function automatic cfg_t derive(input logic [PRB_W-1:0] n, input logic [PRB_W-1:0] h);
        cfg_t         c;
        logic [PRB_W:0] ho;
        logic [PRB_W:0] sub;
        ho          = {1'b0, h} + {{PRB_W{1'b0}}, h[0]};
        sub         = ho + {{PRB_W{1'b0}}, n[0]};
        c.n         = n;
        c.half_ho   = ho[PRB_W:1];
        c.hop_bad   = (sub >= {1'b0, n});
        c.w         = n - sub[PRB_W-1:0];
        c.w_quarter = {2'b00, c.w[PRB_W-1:2]};
        c.w_half    = {1'b0, c.w[PRB_W-1:1]};
        return c;
    endfunction

    assign cfg.ready = 1'b1;
    assign info_next = derive(n_reg, h_reg);
    assign info      = info_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= PRB_COUNT_RESET;
            h_reg    <= HOPPING_OFFSET_RESET;
            info_reg <= derive(PRB_COUNT_RESET, HOPPING_OFFSET_RESET);
        end
        else
        begin
            info_reg <= info_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_PRB_COUNT:      n_reg <= cfg.data;
                    CFG_HOPPING_OFFSET: h_reg <= cfg.data;
                    default:            ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/pusch_prb_allocation_hopping.sv =====
// PUSCH PRB allocation with type-1/type-2 frequency hopping. Each grant word (riv, mode)
// yields one allocation word on alloc after passing through every pipe stage, and a new
// grant is taken every cycle while the pipe is not stalled. The 8 stages are set by the
// riv/prb_count restoring divider (4+3+3+3 bits over four stages), the mirror and hop
// stages, and the modulo-width remainder (two stages).
// The whole pipe stalls only while the output register holds a word not yet taken.
// Config writes are always ready; the value and then its derived copy are registered.
// On status 1 the count and start fields read zero; hop_kind still shows the mode's kind.
`default_nettype none

module pusch_prb_allocation_hopping import ppah_pkg::*;
#(
    parameter int MAX_PRB_COUNT = 110
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ppah_cfg_if.sink  cfg,
    ppah_in_if.sink   grant,
    ppah_out_if.source alloc
);

    localparam int             STAGES = 8;
    localparam logic [PRB_W-1:0] MAX_N = PRB_W'(MAX_PRB_COUNT);

    typedef struct packed {
        logic [RIV_W-1:0]  riv;
        logic [RIV_W-1:0]  quo;
        logic [PRB_W-1:0]  rem;
        logic [MODE_W-1:0] mode;
        logic [KIND_W-1:0] kind;
        logic              bad;
        logic [PRB_W-1:0]  len;
        logic [PRB_W-1:0]  s0;
        logic [PRB_W-1:0]  s1;
        logic [PRB_W:0]    x;
        logic              need_mod;
    } stage_t;

    cfg_t              cfg_info;
    logic              n_bad;
    logic              adv;
    logic [STAGES:1]   v_reg;
    stage_t            st_reg  [1:STAGES];
    stage_t            st_next [1:STAGES];

    ppah_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .info  (cfg_info)
    );

    assign n_bad       = (cfg_info.n == '0) || (cfg_info.n > MAX_N);
    assign adv         = !v_reg[STAGES] || alloc.ready;
    assign grant.ready = adv;

    // Decode and first four quotient bits.
    always_comb
    begin : stage1
        stage_t         s;
        logic [PRB_W:0] step;
        s      = '0;
        s.riv  = grant.riv;
        s.mode = grant.mode;
        case (grant.mode)
            MODE_NONE:        s.kind = HOP_NONE;
            MODE_QUARTER:     s.kind = HOP_TYPE1;
            MODE_NEG_QUARTER: s.kind = HOP_TYPE1;
            MODE_HALF:        s.kind = HOP_TYPE1;
            MODE_TYPE2:       s.kind = HOP_TYPE2;
            default:
            begin
                s.kind = HOP_NONE;
                s.bad  = 1'b1;
            end
        endcase
        if (n_bad)
        begin
            s.bad = 1'b1;
        end
        for (int i = 0; i < 4; i++)
        begin
            step  = div_step(s.rem, grant.riv[RIV_W-1-i], cfg_info.n);
            s.quo = {s.quo[RIV_W-2:0], step[PRB_W]};
            s.rem = step[PRB_W-1:0];
        end
        st_next[1] = s;
    end

    // Remaining quotient bits, three per stage.
    for (genvar k = 2; k <= 4; k++)
    begin : stage_div
        always_comb
        begin : div_bits
            stage_t         s;
            logic [PRB_W:0] step;
            s = st_reg[k-1];
            for (int i = 0; i < 3; i++)
            begin
                step  = div_step(s.rem, s.riv[RIV_W-5-3*(k-2)-i], cfg_info.n);
                s.quo = {s.quo[RIV_W-2:0], step[PRB_W]};
                s.rem = step[PRB_W-1:0];
            end
            st_next[k] = s;
        end
    end

    // Count and start, mirrored when the allocation wraps.
    always_comb
    begin : stage5
        stage_t           s;
        logic [RIV_W:0]   len_w;
        logic [RIV_W:0]   lim;
        logic [RIV_W:0]   n2;
        logic [RIV_W:0]   mirrored;
        s        = st_reg[4];
        len_w    = {1'b0, s.quo} + 1'b1;
        lim      = {{(RIV_W+1-PRB_W){1'b0}}, cfg_info.n - s.rem};
        n2       = {{(RIV_W+1-PRB_W){1'b0}}, cfg_info.n} + 2'd2;
        mirrored = n2 - len_w;
        s.len    = len_w[PRB_W-1:0];
        s.s0     = s.rem;
        if (len_w > lim)
        begin
            if (len_w >= n2)
            begin
                s.bad = 1'b1;
            end
            s.len = mirrored[PRB_W-1:0];
            s.s0  = cfg_info.n - s.rem - 1'b1;
        end
        st_next[5] = s;
    end

    // Slot-zero overrun, type-1 checks and slot-one offset.
    always_comb
    begin : stage6
        stage_t         s;
        logic [PRB_W:0] end0;
        s          = st_reg[5];
        end0       = {1'b0, s.s0} + {1'b0, s.len};
        s.s1       = s.s0;
        s.x        = '0;
        s.need_mod = 1'b0;
        if (end0 > {1'b0, cfg_info.n})
        begin
            s.bad = 1'b1;
        end
        if (s.kind == HOP_TYPE1 && (s.s0 < cfg_info.half_ho || cfg_info.hop_bad))
        begin
            s.bad = 1'b1;
        end
        case (s.mode)
            MODE_QUARTER:
            begin
                s.x        = {1'b0, s.s0} + {1'b0, cfg_info.w_quarter};
                s.need_mod = 1'b1;
            end
            MODE_HALF:
            begin
                s.x        = {1'b0, s.s0} + {1'b0, cfg_info.w_half};
                s.need_mod = 1'b1;
            end
            MODE_NEG_QUARTER:
            begin
                if (s.s0 < cfg_info.w_quarter)
                begin
                    s.s1 = cfg_info.w + s.s0 - cfg_info.w_quarter;
                end
                else
                begin
                    s.s1 = s.s0 - cfg_info.w_quarter;
                end
            end
            default: s.s1 = s.s0;
        endcase
        st_next[6] = s;
    end

    // Modulo width, upper four bits.
    always_comb
    begin : stage7
        stage_t         s;
        logic [PRB_W:0] step;
        s     = st_reg[6];
        s.rem = '0;
        for (int i = 0; i < 4; i++)
        begin
            step  = div_step(s.rem, s.x[PRB_W-i], cfg_info.w);
            s.rem = step[PRB_W-1:0];
        end
        st_next[7] = s;
    end

    // Modulo width, lower four bits, slot-one overrun and result.
    always_comb
    begin : stage8
        stage_t         s;
        logic [PRB_W:0] step;
        logic [PRB_W:0] end1;
        s = st_reg[7];
        for (int i = 0; i < 4; i++)
        begin
            step  = div_step(s.rem, s.x[3-i], cfg_info.w);
            s.rem = step[PRB_W-1:0];
        end
        if (s.need_mod)
        begin
            s.s1 = s.rem;
        end
        end1 = {1'b0, s.s1} + {1'b0, s.len};
        if (end1 > {1'b0, cfg_info.n})
        begin
            s.bad = 1'b1;
        end
        if (s.bad)
        begin
            s.len = '0;
            s.s0  = '0;
            s.s1  = '0;
        end
        st_next[8] = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STAGES-1:1], grant.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 1; k <= STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign alloc.valid       = v_reg[STAGES];
    assign alloc.block_count = st_reg[STAGES].len;
    assign alloc.start_slot0 = st_reg[STAGES].s0;
    assign alloc.start_slot1 = st_reg[STAGES].s1;
    assign alloc.hop_kind    = st_reg[STAGES].kind;
    assign alloc.status      = st_reg[STAGES].bad;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;
    import ppah_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRB    = 110;
    localparam int PIPE_DEPTH = 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_SHOWN  = 10;

    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [PRB_W-1:0]  block_count;
        logic [PRB_W-1:0]  start_slot0;
        logic [PRB_W-1:0]  start_slot1;
        logic [KIND_W-1:0] hop_kind;
        logic              status;
    } alloc_word_t;

    typedef struct packed {
        logic [PRB_W-1:0]  bw;
        logic [PRB_W-1:0]  ofs;
        logic [RIV_W-1:0]  riv;
        logic [MODE_W-1:0] mode;
        logic              typed;
        alloc_word_t       want;
    } grant_row_t;

    logic clk;
    logic rst_n;

    ppah_cfg_if cfg_if ();
    ppah_in_if  grant_if ();
    ppah_out_if alloc_if ();

    pusch_prb_allocation_hopping #(
        .MAX_PRB_COUNT(MAX_PRB)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .grant (grant_if),
        .alloc (alloc_if)
    );

    logic [PRB_W-1:0] bw_cfg;
    logic [PRB_W-1:0] ofs_cfg;

    alloc_word_t expected_allocs[$];
    grant_row_t  dir_rows[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int          mismatches;
    int          errors;
    int          grants_sent;
    int          allocs_checked;
    int          cfg_writes;
    int          idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic alloc_word_t mk_alloc(input int cnt, input int s0, input int s1,
                                             input logic [KIND_W-1:0] kind, input logic st);
        alloc_word_t a;
        a.block_count = cnt[PRB_W-1:0];
        a.start_slot0 = s0[PRB_W-1:0];
        a.start_slot1 = s1[PRB_W-1:0];
        a.hop_kind    = kind;
        a.status      = st;
        return a;
    endfunction

    function automatic grant_row_t mk_row(input int bw, input int ofs, input int riv,
                                          input logic [MODE_W-1:0] mode, input logic typed,
                                          input alloc_word_t want);
        grant_row_t r;
        r.bw    = bw[PRB_W-1:0];
        r.ofs   = ofs[PRB_W-1:0];
        r.riv   = riv[RIV_W-1:0];
        r.mode  = mode;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Allocation for one grant under the current register copy.
    function automatic alloc_word_t predict_alloc(input logic [RIV_W-1:0] riv,
                                                  input logic [MODE_W-1:0] mode);
        int unsigned       n;
        int unsigned       r;
        int unsigned       len;
        int unsigned       s0;
        int unsigned       s1;
        int unsigned       ho;
        int unsigned       sub;
        int unsigned       w;
        logic [KIND_W-1:0] kind;
        logic              bad;
        n    = bw_cfg;
        r    = riv;
        len  = 0;
        s0   = 0;
        s1   = 0;
        bad  = 1'b0;
        kind = HOP_NONE;
        case (mode)
            MODE_NONE: ;
            MODE_QUARTER, MODE_NEG_QUARTER, MODE_HALF: kind = HOP_TYPE1;
            MODE_TYPE2: kind = HOP_TYPE2;
            default: bad = 1'b1;
        endcase
        if (n == 0 || n > MAX_PRB)
        begin
            bad = 1'b1;
        end
        if (!bad)
        begin
            len = r / n + 1;
            s0  = r % n;
            if (len > n - s0)
            begin
                if (len >= n + 2)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    len = n + 2 - len;
                    s0  = n - s0 - 1;
                end
            end
        end
        if (!bad)
        begin
            if (kind != HOP_TYPE1)
            begin
                s1 = s0;
            end
            else
            begin
                ho  = ofs_cfg + (ofs_cfg & 1);
                sub = ho + (n & 1);
                if (s0 < ho / 2 || sub >= n)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    w = n - sub;
                    case (mode)
                        MODE_QUARTER: s1 = (w / 4 + s0) % w;
                        MODE_NEG_QUARTER: s1 = (s0 < w / 4) ? w + s0 - w / 4 : s0 - w / 4;
                        default: s1 = (w / 2 + s0) % w;
                    endcase
                end
            end
        end
        if (!bad && (s0 + len > n || s1 + len > n))
        begin
            bad = 1'b1;
        end
        if (bad)
        begin
            len = 0;
            s0  = 0;
            s1  = 0;
        end
        return mk_alloc(len, s0, s1, kind, bad);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PRB_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        if (idx == CFG_PRB_COUNT)
        begin
            bw_cfg = data;
        end
        else
        begin
            ofs_cfg = data;
        end
        cfg_writes++;
    endtask

    // Drain the pipe, then rewrite both registers.
    task automatic apply_config(input logic [PRB_W-1:0] bw, input logic [PRB_W-1:0] ofs);
        grant_if.valid <= 1'b0;
        while (expected_allocs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        write_reg(CFG_PRB_COUNT, bw);
        write_reg(CFG_HOPPING_OFFSET, ofs);
        cfg_if.valid <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    task automatic send_grant(input logic [RIV_W-1:0] riv, input logic [MODE_W-1:0] mode,
                              input logic typed, input alloc_word_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            grant_if.valid <= 1'b0;
            @(posedge clk);
        end
        grant_if.valid <= 1'b1;
        grant_if.riv   <= riv;
        grant_if.mode  <= mode;
        @(posedge clk);
        while (!grant_if.ready)
        begin
            @(posedge clk);
        end
        expected_allocs.push_back(typed ? want : predict_alloc(riv, mode));
        grants_sent++;
    endtask

    // Receiver: random back-pressure and the scoreboard.
    always @(posedge clk)
    begin
        alloc_word_t want;
        alloc_word_t got;
        alloc_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && alloc_if.valid && alloc_if.ready)
        begin
            got.block_count = alloc_if.block_count;
            got.start_slot0 = alloc_if.start_slot0;
            got.start_slot1 = alloc_if.start_slot1;
            got.hop_kind    = alloc_if.hop_kind;
            got.status      = alloc_if.status;
            if (expected_allocs.size() == 0)
            begin
                errors++;
                if (errors + mismatches <= MAX_SHOWN)
                begin
                    $display("unexpected alloc word cnt=%0d s0=%0d s1=%0d kind=%0d st=%0d",
                             got.block_count, got.start_slot0, got.start_slot1,
                             got.hop_kind, got.status);
                end
            end
            else
            begin
                want = expected_allocs.pop_front();
                allocs_checked++;
                if (got.block_count !== want.block_count || got.start_slot0 !== want.start_slot0
                    || got.start_slot1 !== want.start_slot1 || got.hop_kind !== want.hop_kind
                    || got.status !== want.status)
                begin
                    mismatches++;
                    if (errors + mismatches <= MAX_SHOWN)
                    begin
                        $display("mismatch word %0d: exp cnt=%0d s0=%0d s1=%0d kind=%0d st=%0d",
                                 allocs_checked, want.block_count, want.start_slot0,
                                 want.start_slot1, want.hop_kind, want.status);
                        $display("                  got cnt=%0d s0=%0d s1=%0d kind=%0d st=%0d",
                                 got.block_count, got.start_slot0, got.start_slot1,
                                 got.hop_kind, got.status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles = 0;
        end
        else if ((grant_if.valid && grant_if.ready) || (alloc_if.valid && alloc_if.ready)
                 || (cfg_if.valid && cfg_if.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                         idle_cycles, expected_allocs.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned      n;
        int unsigned      cnt;
        int unsigned      st;
        int unsigned      v;
        int               items;
        logic [RIV_W-1:0] riv;
        logic [MODE_W-1:0] mode;
        logic [PRB_W-1:0] bw;
        logic [PRB_W-1:0] ofs;

        rst_n          = 1'b0;
        grant_if.valid = 1'b0;
        grant_if.riv   = '0;
        grant_if.mode  = MODE_NONE;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = CFG_PRB_COUNT;
        cfg_if.data    = '0;
        alloc_if.ready = 1'b0;
        bw_cfg         = PRB_COUNT_RESET;
        ofs_cfg        = HOPPING_OFFSET_RESET;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        errors         = 0;
        grants_sent    = 0;
        allocs_checked = 0;
        cfg_writes     = 0;
        idle_cycles    = 0;

        dir_rows.push_back(mk_row(100, 0, 0, MODE_NONE, 1, mk_alloc(1, 0, 0, HOP_NONE, 0)));
        dir_rows.push_back(mk_row(100, 0, 8191, MODE_NONE, 1, mk_alloc(20, 8, 8, HOP_NONE, 0)));
        dir_rows.push_back(mk_row(100, 0, 0, MODE_QUARTER, 1, mk_alloc(1, 0, 25, HOP_TYPE1, 0)));
        dir_rows.push_back(mk_row(100, 0, 0, MODE_NEG_QUARTER, 1,
                                  mk_alloc(1, 0, 75, HOP_TYPE1, 0)));
        dir_rows.push_back(mk_row(100, 0, 0, MODE_HALF, 1, mk_alloc(1, 0, 50, HOP_TYPE1, 0)));
        dir_rows.push_back(mk_row(100, 0, 0, MODE_TYPE2, 1, mk_alloc(1, 0, 0, HOP_TYPE2, 0)));
        dir_rows.push_back(mk_row(100, 0, 0, MODE_UNDEF_LO, 1, mk_alloc(0, 0, 0, HOP_NONE, 1)));
        dir_rows.push_back(mk_row(100, 0, 8191, MODE_UNDEF_HI, 1,
                                  mk_alloc(0, 0, 0, HOP_NONE, 1)));
        // slot one overrun
        dir_rows.push_back(mk_row(100, 0, 4940, MODE_QUARTER, 1,
                                  mk_alloc(0, 0, 0, HOP_TYPE1, 1)));
        dir_rows.push_back(mk_row(100, 0, 4940, MODE_HALF, 0, '0));
        dir_rows.push_back(mk_row(100, 0, 99, MODE_NEG_QUARTER, 0, '0));
        // odd offset rounds up: start below half offset, then just at it
        dir_rows.push_back(mk_row(100, 1, 0, MODE_QUARTER, 1, mk_alloc(0, 0, 0, HOP_TYPE1, 1)));
        dir_rows.push_back(mk_row(100, 1, 1, MODE_QUARTER, 1, mk_alloc(1, 1, 25, HOP_TYPE1, 0)));
        // hopping width zero, then underflow
        dir_rows.push_back(mk_row(100, 99, 99, MODE_HALF, 1, mk_alloc(0, 0, 0, HOP_TYPE1, 1)));
        dir_rows.push_back(mk_row(100, 127, 99, MODE_QUARTER, 1,
                                  mk_alloc(0, 0, 0, HOP_TYPE1, 1)));
        dir_rows.push_back(mk_row(110, 0, 0, MODE_HALF, 1, mk_alloc(1, 0, 55, HOP_TYPE1, 0)));
        dir_rows.push_back(mk_row(110, 0, 8191, MODE_TYPE2, 0, '0));
        dir_rows.push_back(mk_row(7, 0, 0, MODE_QUARTER, 1, mk_alloc(1, 0, 1, HOP_TYPE1, 0)));
        // mirrored count underflow, then mirrored count of one
        dir_rows.push_back(mk_row(6, 0, 8191, MODE_NONE, 1, mk_alloc(0, 0, 0, HOP_NONE, 1)));
        dir_rows.push_back(mk_row(6, 0, 41, MODE_NONE, 0, '0));
        dir_rows.push_back(mk_row(6, 0, 35, MODE_QUARTER, 0, '0));
        dir_rows.push_back(mk_row(0, 0, 0, MODE_NONE, 1, mk_alloc(0, 0, 0, HOP_NONE, 1)));
        dir_rows.push_back(mk_row(111, 0, 0, MODE_NONE, 1, mk_alloc(0, 0, 0, HOP_NONE, 1)));
        dir_rows.push_back(mk_row(127, 127, 8191, MODE_TYPE2, 1,
                                  mk_alloc(0, 0, 0, HOP_TYPE2, 1)));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].bw != bw_cfg || dir_rows[i].ofs != ofs_cfg)
            begin
                apply_config(dir_rows[i].bw, dir_rows[i].ofs);
            end
            send_grant(dir_rows[i].riv, dir_rows[i].mode, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: begin bw = 7'd110; ofs = 7'd0; end
                1: begin bw = 7'd6; ofs = 7'd0; end
                2: begin bw = 7'd0; ofs = 7'($urandom_range(127)); end
                3: begin bw = 7'd127; ofs = 7'd127; end
                default:
                begin
                    bw  = 7'($urandom_range(MAX_PRB, 6));
                    ofs = ($urandom_range(1) != 0) ? 7'($urandom_range(bw / 2))
                                                   : 7'($urandom_range(127));
                end
            endcase
            apply_config(bw, ofs);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 78; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 78; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            items = (ph == 2 || ph == 3) ? 40 : 140;
            n = bw_cfg;
            for (int k = 0; k < items; k++)
            begin
                if (n >= 1 && n <= MAX_PRB && $urandom_range(99) < 70)
                begin
                    cnt = $urandom_range(n, 1);
                    st  = $urandom_range(n - cnt, 0);
                    if (cnt - 1 <= n / 2)
                    begin
                        v = n * (cnt - 1) + st;
                    end
                    else
                    begin
                        v = n * (n - cnt + 1) + (n - 1 - st);
                    end
                    riv = v[RIV_W-1:0];
                end
                else
                begin
                    riv = RIV_W'($urandom_range(8191));
                end
                if ($urandom_range(99) < 8)
                begin
                    mode = MODE_W'($urandom_range(MODE_UNDEF_HI, MODE_UNDEF_LO));
                end
                else
                begin
                    mode = MODE_W'($urandom_range(MODE_TYPE2, MODE_NONE));
                end
                send_grant(riv, mode, 1'b0, '0);
            end
        end

        grant_if.valid <= 1'b0;
        while (expected_allocs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        $display("sent %0d grants over %0d register writes, %0d allocation words checked",
                 grants_sent, cfg_writes, allocs_checked);
        $display("bandwidths 0..127 and offsets 0..127 with all hopping modes and gap patterns");
        if (mismatches == 0 && errors == 0 && expected_allocs.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d unexpected words", mismatches, errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/ppah_pkg.sv
src/ppah_if.sv
src/ppah_cfg.sv
src/pusch_prb_allocation_hopping.sv
verif/tb_top.sv
